FILE: hw/rtl/pwl_pkg.sv
// ----------------------------------------------------------------------------
// pwl_pkg
// Types and constants shared by the interpolation table blocks.
// ----------------------------------------------------------------------------
package pwl_pkg;

    localparam int KEY_W = 32;
    localparam int VAL_W = 48;
    localparam int SEG_W = 7;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_NOP    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_NOBRACK = 2'd2,
        ST_RSVD    = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        OP_CLEAR  = 4'b0001,
        OP_APPEND = 4'b0010,
        OP_QUERY  = 4'b0100,
        OP_NOP    = 4'b1000
    } t_op;

    typedef struct packed {
        logic [1:0]               command;
        logic signed [KEY_W-1:0]  key;
        logic signed [VAL_W-1:0]  first_value;
        logic signed [VAL_W-1:0]  second_value;
    } t_in_word;

    typedef struct packed {
        logic [1:0]               status;
        logic [SEG_W-1:0]         segment_index;
        logic signed [VAL_W-1:0]  first_result;
        logic signed [VAL_W-1:0]  second_result;
    } t_out_word;

    typedef struct packed {
        t_op                      op;
        logic signed [KEY_W-1:0]  key;
        logic signed [VAL_W-1:0]  first_value;
        logic signed [VAL_W-1:0]  second_value;
    } t_q_word;

endpackage

FILE: hw/rtl/pwl_ram.sv
// ----------------------------------------------------------------------------
// pwl_ram
// Generic simple dual-port RAM with registered read.
// ----------------------------------------------------------------------------
module pwl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hw/rtl/pwl_front.sv
// ----------------------------------------------------------------------------
// pwl_front
// Input stage: accept command words and decode them into operations.
// ----------------------------------------------------------------------------
module pwl_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  pwl_pkg::t_in_word i_data,
    output logic              o_push,
    input  logic              i_full,
    output pwl_pkg::t_q_word  o_word
);
    import pwl_pkg::*;

    logic    r_valid, n_valid;
    t_q_word r_word, n_word;
    t_op     dec_op;

    always_comb begin
        case (t_cmd'(i_data.command))
            CMD_CLEAR:  dec_op = OP_CLEAR;
            CMD_APPEND: dec_op = OP_APPEND;
            CMD_QUERY:  dec_op = OP_QUERY;
            default:    dec_op = OP_NOP;
        endcase
    end

    assign o_push  = r_valid && !i_full;
    assign o_ready = !r_valid || !i_full;
    assign o_word  = r_word;

    always_comb begin
        n_valid = r_valid;
        n_word  = r_word;
        if (o_push) begin
            n_valid = 1'b0;
        end
        if (i_valid && o_ready) begin
            n_valid             = 1'b1;
            n_word.op           = dec_op;
            n_word.key          = i_data.key;
            n_word.first_value  = i_data.first_value;
            n_word.second_value = i_data.second_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_word <= n_word;
    end
endmodule

FILE: hw/rtl/pwl_queue.sv
// ----------------------------------------------------------------------------
// pwl_queue
// Two-entry queue between the decode stage and the execution engine.
// ----------------------------------------------------------------------------
module pwl_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  pwl_pkg::t_q_word i_word,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output pwl_pkg::t_q_word o_word
);
    import pwl_pkg::*;

    t_q_word    r_slot [2];
    logic       r_wp, n_wp;
    logic       r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_word  = r_slot[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = ~r_wp;
        end
        if (i_pop) begin
            n_rp = ~r_rp;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
        if (i_push) begin
            r_slot[r_wp] <= i_word;
        end
    end
endmodule

FILE: hw/rtl/pwl_mdiv.sv
// ----------------------------------------------------------------------------
// pwl_mdiv
// Bit-serial floor(mag * a / b) for a <= b, one magnitude bit per cycle.
// ----------------------------------------------------------------------------
module pwl_mdiv (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [pwl_pkg::VAL_W-1:0]  i_mag,
    input  logic [pwl_pkg::KEY_W-1:0]  i_a,
    input  logic [pwl_pkg::KEY_W-1:0]  i_b,
    output logic                       o_done,
    output logic [pwl_pkg::VAL_W-1:0]  o_part
);
    import pwl_pkg::*;

    localparam int CW = $clog2(VAL_W);

    logic             r_busy, r_done;
    logic [CW-1:0]    r_cnt;
    logic [VAL_W-1:0] r_mag, r_q;
    logic [KEY_W:0]   r_rem;
    logic [KEY_W-1:0] r_a, r_b;

    logic [KEY_W+1:0] rem2, rem2s, rem3, rem3s, b_ext;
    logic             c1, c2;
    logic [VAL_W-1:0] q_next;

    always_comb begin
        b_ext  = {2'b00, r_b};
        rem2   = {r_rem, 1'b0};
        c1     = (rem2 >= b_ext);
        rem2s  = c1 ? rem2 - b_ext : rem2;
        rem3   = rem2s + (r_mag[VAL_W-1] ? {2'b00, r_a} : '0);
        c2     = (rem3 >= b_ext);
        rem3s  = c2 ? rem3 - b_ext : rem3;
        q_next = {r_q[VAL_W-2:0], c1} + VAL_W'(c2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
        if (i_start) begin
            r_cnt <= CW'(VAL_W - 1);
            r_mag <= i_mag;
            r_q   <= '0;
            r_rem <= '0;
            r_a   <= i_a;
            r_b   <= i_b;
        end else if (r_busy) begin
            r_cnt <= r_cnt - CW'(1);
            r_mag <= {r_mag[VAL_W-2:0], 1'b0};
            r_q   <= q_next;
            r_rem <= rem3s[KEY_W:0];
        end
    end

    assign o_done = r_done;
    assign o_part = r_q;
endmodule

FILE: hw/rtl/pwl_back.sv
// ----------------------------------------------------------------------------
// pwl_back
// Execution engine: table writes, bracket scan, interpolation, result hold.
// ----------------------------------------------------------------------------
module pwl_back #(
    parameter int DEPTH = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  pwl_pkg::t_q_word   i_q_word,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output pwl_pkg::t_out_word o_data
);
    import pwl_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int EXT_W = (IDX_W > SEG_W) ? IDX_W : SEG_W;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_SCAN = 7'b0000010,
        S_VLO  = 7'b0000100,
        S_VHI  = 7'b0001000,
        S_DIV1 = 7'b0010000,
        S_DIV2 = 7'b0100000,
        S_RESP = 7'b1000000
    } t_bstate;

    t_bstate                 r_state, n_state;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic [IDX_W-1:0]        r_idx, n_idx, r_seg, n_seg;
    logic                    r_have, n_have;
    logic signed [KEY_W-1:0] r_x, n_x, r_prev, n_prev, r_x2, n_x2;
    logic signed [VAL_W-1:0] r_y1a, n_y1a, r_y1b, n_y1b, r_y2a, n_y2a, r_y2b, n_y2b;
    logic [VAL_W-1:0]        r_part1, n_part1;
    logic                    r_kick, n_kick;
    t_out_word               r_res, n_res, r_out, n_out;
    logic                    r_out_valid, n_out_valid;

    logic                    k_we, v_we;
    logic [IDX_W-1:0]        k_raddr, v_raddr, w_addr;
    logic signed [KEY_W-1:0] k_rdata;
    logic [2*VAL_W-1:0]      v_rdata;

    logic [KEY_W:0]          a_ext, b_ext;
    logic [VAL_W:0]          d1, d2;
    logic [VAL_W-1:0]        mag1, mag2;
    logic                    div_done;
    logic [VAL_W-1:0]        div_part;
    logic [EXT_W-1:0]        seg_ext;
    logic                    slot_free;

    function automatic logic signed [VAL_W-1:0] f_apply(
        input logic signed [VAL_W-1:0] y1,
        input logic [VAL_W-1:0]        part,
        input logic                    neg
    );
        logic signed [VAL_W+1:0] s;
        s = neg ? $signed({{2{y1[VAL_W-1]}}, y1}) - $signed({2'b00, part})
                : $signed({{2{y1[VAL_W-1]}}, y1}) + $signed({2'b00, part});
        if (s > $signed({2'b00, 1'b0, {(VAL_W-1){1'b1}}})) begin
            f_apply = {1'b0, {(VAL_W-1){1'b1}}};
        end else if (s < $signed({2'b11, 1'b1, {(VAL_W-1){1'b0}}})) begin
            f_apply = {1'b1, {(VAL_W-1){1'b0}}};
        end else begin
            f_apply = s[VAL_W-1:0];
        end
    endfunction

    pwl_ram #(.WIDTH(KEY_W), .DEPTH(DEPTH)) u_key_ram (
        .i_clk  (i_clk),
        .i_we   (k_we),
        .i_waddr(w_addr),
        .i_wdata(i_q_word.key),
        .i_raddr(k_raddr),
        .o_rdata(k_rdata)
    );

    pwl_ram #(.WIDTH(2 * VAL_W), .DEPTH(DEPTH)) u_val_ram (
        .i_clk  (i_clk),
        .i_we   (v_we),
        .i_waddr(w_addr),
        .i_wdata({i_q_word.first_value, i_q_word.second_value}),
        .i_raddr(v_raddr),
        .o_rdata(v_rdata)
    );

    assign a_ext = {r_x[KEY_W-1], r_x} - {r_prev[KEY_W-1], r_prev};
    assign b_ext = {r_x2[KEY_W-1], r_x2} - {r_prev[KEY_W-1], r_prev};
    assign d1    = {r_y2a[VAL_W-1], r_y2a} - {r_y1a[VAL_W-1], r_y1a};
    assign d2    = {r_y2b[VAL_W-1], r_y2b} - {r_y1b[VAL_W-1], r_y1b};
    assign mag1  = d1[VAL_W] ? VAL_W'(-d1) : d1[VAL_W-1:0];
    assign mag2  = d2[VAL_W] ? VAL_W'(-d2) : d2[VAL_W-1:0];

    pwl_mdiv u_mdiv (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_kick),
        .i_mag  ((r_state == S_DIV2) ? mag2 : mag1),
        .i_a    (a_ext[KEY_W-1:0]),
        .i_b    (b_ext[KEY_W-1:0]),
        .o_done (div_done),
        .o_part (div_part)
    );

    assign w_addr    = r_cnt[IDX_W-1:0];
    assign seg_ext   = EXT_W'(r_seg);
    assign slot_free = !r_out_valid || i_ready;
    assign o_pop     = (r_state == S_IDLE) && i_q_valid;
    assign o_valid   = r_out_valid;
    assign o_data    = r_out;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_seg       = r_seg;
        n_have      = r_have;
        n_x         = r_x;
        n_prev      = r_prev;
        n_x2        = r_x2;
        n_y1a       = r_y1a;
        n_y1b       = r_y1b;
        n_y2a       = r_y2a;
        n_y2b       = r_y2b;
        n_part1     = r_part1;
        n_kick      = 1'b0;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_ready;
        k_we        = 1'b0;
        v_we        = 1'b0;
        k_raddr     = r_idx;
        v_raddr     = r_seg;

        case (r_state)
            S_IDLE: begin
                k_raddr = '0;
                if (i_q_valid) begin
                    n_res   = '0;
                    n_state = S_RESP;
                    case (i_q_word.op)
                        OP_CLEAR: begin
                            n_cnt = '0;
                        end
                        OP_APPEND: begin
                            if (r_cnt >= CNT_W'(DEPTH)) begin
                                n_res.status = ST_FULL;
                            end else begin
                                k_we  = 1'b1;
                                v_we  = 1'b1;
                                n_cnt = r_cnt + CNT_W'(1);
                            end
                        end
                        OP_QUERY: begin
                            n_x = i_q_word.key;
                            if (r_cnt < CNT_W'(2)) begin
                                n_res.status = ST_NOBRACK;
                            end else begin
                                n_idx   = '0;
                                n_have  = 1'b0;
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (r_have && r_prev <= r_x && k_rdata >= r_x) begin
                    n_x2    = k_rdata;
                    n_seg   = r_idx - IDX_W'(1);
                    v_raddr = r_idx - IDX_W'(1);
                    n_state = S_VLO;
                end else if ({1'b0, r_idx} + (IDX_W+1)'(1) == (IDX_W+1)'(r_cnt)) begin
                    n_res.status = ST_NOBRACK;
                    n_state      = S_RESP;
                end else begin
                    n_prev  = k_rdata;
                    n_have  = 1'b1;
                    n_idx   = r_idx + IDX_W'(1);
                    k_raddr = r_idx + IDX_W'(1);
                end
            end
            S_VLO: begin
                n_y1a   = v_rdata[2*VAL_W-1:VAL_W];
                n_y1b   = v_rdata[VAL_W-1:0];
                v_raddr = r_seg + IDX_W'(1);
                n_state = S_VHI;
            end
            S_VHI: begin
                n_y2a                = v_rdata[2*VAL_W-1:VAL_W];
                n_y2b                = v_rdata[VAL_W-1:0];
                n_res.status         = ST_OK;
                n_res.segment_index  = seg_ext[SEG_W-1:0];
                if (r_x2 == r_prev) begin
                    n_res.first_result  = r_y1a;
                    n_res.second_result = r_y1b;
                    n_state             = S_RESP;
                end else begin
                    n_kick  = 1'b1;
                    n_state = S_DIV1;
                end
            end
            S_DIV1: begin
                if (div_done) begin
                    n_part1 = div_part;
                    n_kick  = 1'b1;
                    n_state = S_DIV2;
                end
            end
            S_DIV2: begin
                if (div_done) begin
                    n_res.first_result  = f_apply(r_y1a, r_part1, d1[VAL_W]);
                    n_res.second_result = f_apply(r_y1b, div_part, d2[VAL_W]);
                    n_state             = S_RESP;
                end
            end
            S_RESP: begin
                if (slot_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_kick      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_kick      <= n_kick;
            r_out_valid <= n_out_valid;
        end
        r_idx   <= n_idx;
        r_seg   <= n_seg;
        r_have  <= n_have;
        r_x     <= n_x;
        r_prev  <= n_prev;
        r_x2    <= n_x2;
        r_y1a   <= n_y1a;
        r_y1b   <= n_y1b;
        r_y2a   <= n_y2a;
        r_y2b   <= n_y2b;
        r_part1 <= n_part1;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(DEPTH))
        else $error("entry count above table depth");

    a_scan_needs_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_cnt >= CNT_W'(2)))
        else $error("scan with fewer than two entries");

    a_nobrack_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == ST_NOBRACK) |->
        (r_out.segment_index == '0 && r_out.first_result == '0 &&
         r_out.second_result == '0))
        else $error("unbracketed query carries nonzero fields");

    a_kick_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_kick |-> (r_state == S_DIV1 || r_state == S_DIV2))
        else $error("divider started outside interpolation");
endmodule

FILE: hw/rtl/piecewise_linear_interp_table_top.sv
// Clear, append and rejected commands pass from idle straight to the response state.
// A query scans the table for its bracket, one table entry per cycle, then reads the
// endpoint values and, unless the segment is zero-wide, divides each series in turn.
// Items are executed one at a time; a two-entry queue lets commands wait meanwhile.
// Reset (synchronous, active low) empties the table and drops all queued words.
// ----------------------------------------------------------------------------
// piecewise_linear_interp_table_top
// Breakpoint table with append, clear and linearly interpolated queries.
// ----------------------------------------------------------------------------
module piecewise_linear_interp_table_top #(
    parameter int TABLE_DEPTH = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  pwl_pkg::t_in_word  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output pwl_pkg::t_out_word o_data
);
    import pwl_pkg::*;

    logic    f_push, q_full, q_valid, q_pop;
    t_q_word f_word, q_word;

    pwl_front u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_data (i_data),
        .o_push (f_push),
        .i_full (q_full),
        .o_word (f_word)
    );

    pwl_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (f_push),
        .i_word (f_word),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_valid(q_valid),
        .o_word (q_word)
    );

    pwl_back #(.DEPTH(TABLE_DEPTH)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_valid(q_valid),
        .i_q_word (q_word),
        .o_pop    (q_pop),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_data   (o_data)
    );
endmodule
